FILE: src/bsc_pkg.sv
package bsc_pkg;

  localparam int unsigned TEMP_FRAC_BITS  = 16;
  localparam int unsigned PRESS_FRAC_BITS = 6;

  // Multiplier geometry: wide operand cut into 24-bit chunks
  localparam int unsigned MUL_CH  = 24;
  localparam int unsigned MUL_A_W = 96;
  localparam int unsigned MUL_B_W = 26;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_NCH = MUL_A_W / MUL_CH;

  localparam int unsigned ACC_W   = 3 * TEMP_FRAC_BITS + 98;
  localparam int unsigned TEMP_SH = 48 - TEMP_FRAC_BITS;
  localparam int unsigned PRESS_SH = 65 + 3 * TEMP_FRAC_BITS - PRESS_FRAC_BITS;

  localparam int unsigned NUM_COEF = 10;

  localparam logic [1:0] CFG_CALIB_LOW  = 2'd0;
  localparam logic [1:0] CFG_CALIB_MID  = 2'd1;
  localparam logic [1:0] CFG_CALIB_HIGH = 2'd2;

  typedef logic signed [MUL_A_W-1:0]        mul_a_t;
  typedef logic signed [MUL_B_W-1:0]        mul_b_t;
  typedef logic signed [MUL_P_W-1:0]        mul_p_t;
  typedef logic signed [MUL_CH+MUL_B_W:0]   mul_pp_t;
  typedef logic signed [ACC_W-1:0]          acc_t;
  typedef logic signed [16:0]               coef_t;

  // Left shift of each pressure term on the common 2^(65+3F) grid.
  // Term 0 is the constant offset, terms 1..10 follow the coefficient order.
  function automatic int unsigned term_shift(int unsigned k);
    int unsigned sh;
    sh = 0;
    unique case (k)
      0:       sh = 68 + 3 * TEMP_FRAC_BITS;
      1:       sh = 59 + 2 * TEMP_FRAC_BITS;
      2:       sh = 57 + TEMP_FRAC_BITS;
      3:       sh = 50;
      4:       sh = 45 + 3 * TEMP_FRAC_BITS;
      5:       sh = 36 + 2 * TEMP_FRAC_BITS;
      6:       sh = 33 + TEMP_FRAC_BITS;
      7:       sh = 28;
      8:       sh = 17 + 3 * TEMP_FRAC_BITS;
      9:       sh = 17 + 2 * TEMP_FRAC_BITS;
      10:      sh = 3 * TEMP_FRAC_BITS;
      default: sh = 0;
    endcase
    return sh;
  endfunction

endpackage

FILE: src/baro_sensor_compensation_unit.sv
// Barometric compensation pipeline: one raw temperature/pressure pair enters per clock
// unless the pipeline is stalled (throughput one item per cycle). The depth comes from the
// input and offset registers and the chain of 24-bit-chunk multipliers, each with a
// partial-product and a sum register: two for temperature (d*d, then times T3, with d*T2
// alongside), three for the temperature/pressure monomials, one for the coefficients, then a
// three-level adder tree and the floor/clamp stage. A stall on the output freezes the whole
// pipeline while a result waits, and the input stalls only then. Calibration registers must be
// written only while the pipeline is empty; cfg_ready_o is always high.
module baro_sensor_compensation_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [23:0]        adc_temp_i,
  input  logic [23:0]        adc_press_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] temperature_q16_o,
  output logic [23:0]        pressure_q6_o,
  output logic               saturated_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  localparam int unsigned LAST = 18;

  logic [63:0]  calib_low_q, calib_mid_q;
  logic [39:0]  calib_high_q;
  logic [167:0] cal;

  logic          adv, accept;
  logic [LAST:0] vld_q, vld_d;

  logic [23:0]        adc_temp_q;
  logic [23:0]        rp_q [0:12];
  logic signed [25:0] d_q;

  bsc_pkg::mul_p_t    dd_p, dt2_p, ddt3_p;
  logic signed [40:0] dt2_q [4:5];
  logic signed [63:0] v, t_full;
  logic signed [23:0] t_d;
  logic               sat_t_d;
  logic signed [23:0] t_q [6:LAST];
  logic [17:6]        sat_q;

  bsc_pkg::mul_p_t    t2_p, r2_p, rt_p, t3_p, r3_p, rt2_p, r2t_p, rt3_p;
  logic signed [47:0] t2_q  [9:12];
  logic signed [48:0] r2_q  [9:12];
  logic signed [47:0] rt_q  [9:12];
  logic signed [70:0] t3_q  [11:12];
  logic signed [72:0] r3_q  [11:12];
  logic signed [71:0] rt2_q [11:12];
  logic signed [72:0] r2t_q [11:12];

  bsc_pkg::coef_t  coef [bsc_pkg::NUM_COEF];
  bsc_pkg::mul_a_t mono [bsc_pkg::NUM_COEF];
  bsc_pkg::mul_p_t prod [bsc_pkg::NUM_COEF];
  logic [15:0]     c0;

  bsc_pkg::acc_t term [bsc_pkg::NUM_COEF+1];
  bsc_pkg::acc_t pair_d [6];
  bsc_pkg::acc_t pair_q [6];
  bsc_pkg::acc_t quad_d [3];
  bsc_pkg::acc_t quad_q [3];
  bsc_pkg::acc_t acc_d, acc_q;

  logic        p_neg, p_big;
  logic [23:0] press_d, press_q;
  logic        sat_out_d, sat_out_q;

  // Configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_low_q  <= '0;
      calib_mid_q  <= '0;
      calib_high_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bsc_pkg::CFG_CALIB_LOW:  calib_low_q  <= cfg_data_i;
        bsc_pkg::CFG_CALIB_MID:  calib_mid_q  <= cfg_data_i;
        bsc_pkg::CFG_CALIB_HIGH: calib_high_q <= cfg_data_i[39:0];
        default: ;
      endcase
    end
  end

  assign cal = {calib_high_q, calib_mid_q, calib_low_q};

  assign c0      = cal[103:88];
  assign coef[0] = bsc_pkg::coef_t'({1'b0, cal[119:104]});
  assign coef[1] = bsc_pkg::coef_t'($signed(cal[127:120]));
  assign coef[2] = bsc_pkg::coef_t'($signed(cal[135:128]));
  assign coef[3] = bsc_pkg::coef_t'($signed(cal[55:40])) - 17'sd16384;
  assign coef[4] = bsc_pkg::coef_t'($signed(cal[71:56])) - 17'sd16384;
  assign coef[5] = bsc_pkg::coef_t'($signed(cal[79:72]));
  assign coef[6] = bsc_pkg::coef_t'($signed(cal[87:80]));
  assign coef[7] = bsc_pkg::coef_t'($signed(cal[151:136]));
  assign coef[8] = bsc_pkg::coef_t'($signed(cal[159:152]));
  assign coef[9] = bsc_pkg::coef_t'($signed(cal[167:160]));

  // Flow control: the whole pipe advances unless a finished item is held
  assign adv        = !(vld_q[LAST] && out_stall_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;
  assign vld_d      = {vld_q[LAST-1:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // Temperature: d*T2*2^18 + d*d*T3, floored to the output grid and clamped
  bsc_mul u_mul_dd (.clk_i, .en_i(adv), .a_i(bsc_pkg::mul_a_t'(d_q)),
                    .b_i(bsc_pkg::mul_b_t'(d_q)), .p_o(dd_p));
  bsc_mul u_mul_dt2 (.clk_i, .en_i(adv), .a_i(bsc_pkg::mul_a_t'({1'b0, cal[31:16]})),
                     .b_i(bsc_pkg::mul_b_t'(d_q)), .p_o(dt2_p));
  bsc_mul u_mul_ddt3 (.clk_i, .en_i(adv), .a_i(bsc_pkg::mul_a_t'($signed(dd_p[48:0]))),
                      .b_i(bsc_pkg::mul_b_t'($signed(cal[39:32]))), .p_o(ddt3_p));

  always_comb begin
    v = (64'(dt2_q[5]) <<< 18) + 64'($signed(ddt3_p[55:0]));
    t_full = v >>> bsc_pkg::TEMP_SH;
    sat_t_d = 1'b0;
    t_d = t_full[23:0];
    if (t_full > 64'sd8388607) begin
      t_d = 24'sh7FFFFF;
      sat_t_d = 1'b1;
    end else if (t_full < -64'sd8388608) begin
      t_d = 24'sh800000;
      sat_t_d = 1'b1;
    end
  end

  // Monomials in t and r
  bsc_mul u_mul_t2 (.clk_i, .en_i(adv), .a_i(bsc_pkg::mul_a_t'(t_q[6])),
                    .b_i(bsc_pkg::mul_b_t'(t_q[6])), .p_o(t2_p));
  bsc_mul u_mul_r2 (.clk_i, .en_i(adv), .a_i(bsc_pkg::mul_a_t'({1'b0, rp_q[6]})),
                    .b_i(bsc_pkg::mul_b_t'({1'b0, rp_q[6]})), .p_o(r2_p));
  bsc_mul u_mul_rt (.clk_i, .en_i(adv), .a_i(bsc_pkg::mul_a_t'({1'b0, rp_q[6]})),
                    .b_i(bsc_pkg::mul_b_t'(t_q[6])), .p_o(rt_p));

  bsc_mul u_mul_t3 (.clk_i, .en_i(adv), .a_i(bsc_pkg::mul_a_t'($signed(t2_p[47:0]))),
                    .b_i(bsc_pkg::mul_b_t'(t_q[8])), .p_o(t3_p));
  bsc_mul u_mul_r3 (.clk_i, .en_i(adv), .a_i(bsc_pkg::mul_a_t'($signed(r2_p[48:0]))),
                    .b_i(bsc_pkg::mul_b_t'({1'b0, rp_q[8]})), .p_o(r3_p));
  bsc_mul u_mul_rt2 (.clk_i, .en_i(adv), .a_i(bsc_pkg::mul_a_t'($signed(rt_p[47:0]))),
                     .b_i(bsc_pkg::mul_b_t'(t_q[8])), .p_o(rt2_p));
  bsc_mul u_mul_r2t (.clk_i, .en_i(adv), .a_i(bsc_pkg::mul_a_t'($signed(r2_p[48:0]))),
                     .b_i(bsc_pkg::mul_b_t'(t_q[8])), .p_o(r2t_p));

  bsc_mul u_mul_rt3 (.clk_i, .en_i(adv), .a_i(bsc_pkg::mul_a_t'($signed(rt2_p[71:0]))),
                     .b_i(bsc_pkg::mul_b_t'(t_q[10])), .p_o(rt3_p));

  assign mono[0] = bsc_pkg::mul_a_t'(t_q[12]);
  assign mono[1] = bsc_pkg::mul_a_t'(t2_q[12]);
  assign mono[2] = bsc_pkg::mul_a_t'(t3_q[12]);
  assign mono[3] = bsc_pkg::mul_a_t'({1'b0, rp_q[12]});
  assign mono[4] = bsc_pkg::mul_a_t'(rt_q[12]);
  assign mono[5] = bsc_pkg::mul_a_t'(rt2_q[12]);
  assign mono[6] = bsc_pkg::mul_a_t'($signed(rt3_p[94:0]));
  assign mono[7] = bsc_pkg::mul_a_t'(r2_q[12]);
  assign mono[8] = bsc_pkg::mul_a_t'(r2t_q[12]);
  assign mono[9] = bsc_pkg::mul_a_t'(r3_q[12]);

  for (genvar k = 0; k < bsc_pkg::NUM_COEF; k++) begin : g_coef
    bsc_mul u_mul_coef (.clk_i, .en_i(adv), .a_i(mono[k]),
                        .b_i(bsc_pkg::mul_b_t'(coef[k])), .p_o(prod[k]));
  end

  // Align every term on the common grid and reduce
  always_comb begin
    term[0] = bsc_pkg::acc_t'({1'b0, c0}) <<< bsc_pkg::term_shift(0);
    for (int k = 1; k <= bsc_pkg::NUM_COEF; k++) begin
      term[k] = bsc_pkg::acc_t'(prod[k-1]) <<< bsc_pkg::term_shift(k);
    end
    for (int k = 0; k < 5; k++) begin
      pair_d[k] = term[2*k] + term[2*k+1];
    end
    pair_d[5] = term[bsc_pkg::NUM_COEF];
    for (int k = 0; k < 3; k++) begin
      quad_d[k] = pair_q[2*k] + pair_q[2*k+1];
    end
    acc_d = quad_q[0] + quad_q[1] + quad_q[2];
  end

  // Floor to the pressure grid, clamp at both ends
  always_comb begin
    p_neg = acc_q[bsc_pkg::ACC_W-1];
    p_big = |acc_q[bsc_pkg::ACC_W-1:bsc_pkg::PRESS_SH+24];
    press_d = acc_q[bsc_pkg::PRESS_SH +: 24];
    if (p_neg) begin
      press_d = '0;
    end else if (p_big) begin
      press_d = '1;
    end
    sat_out_d = sat_q[17] | p_neg | p_big;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      adc_temp_q <= adc_temp_i;
      rp_q[0]    <= adc_press_i;
      for (int k = 1; k <= 12; k++) rp_q[k] <= rp_q[k-1];
      d_q      <= $signed({2'b00, adc_temp_q}) - $signed({2'b00, cal[15:0], 8'h00});
      dt2_q[4] <= $signed(dt2_p[40:0]);
      dt2_q[5] <= dt2_q[4];
      t_q[6]   <= t_d;
      sat_q[6] <= sat_t_d;
      for (int k = 7; k <= LAST; k++) t_q[k] <= t_q[k-1];
      for (int k = 7; k <= 17; k++) sat_q[k] <= sat_q[k-1];
      t2_q[9]  <= $signed(t2_p[47:0]);
      r2_q[9]  <= $signed(r2_p[48:0]);
      rt_q[9]  <= $signed(rt_p[47:0]);
      for (int k = 10; k <= 12; k++) begin
        t2_q[k] <= t2_q[k-1];
        r2_q[k] <= r2_q[k-1];
        rt_q[k] <= rt_q[k-1];
      end
      t3_q[11]  <= $signed(t3_p[70:0]);
      r3_q[11]  <= $signed(r3_p[72:0]);
      rt2_q[11] <= $signed(rt2_p[71:0]);
      r2t_q[11] <= $signed(r2t_p[72:0]);
      t3_q[12]  <= t3_q[11];
      r3_q[12]  <= r3_q[11];
      rt2_q[12] <= rt2_q[11];
      r2t_q[12] <= r2t_q[11];
      pair_q    <= pair_d;
      quad_q    <= quad_d;
      acc_q     <= acc_d;
      press_q   <= press_d;
      sat_out_q <= sat_out_d;
    end
  end

  assign out_valid_o       = vld_q[LAST];
  assign temperature_q16_o = t_q[LAST];
  assign pressure_q6_o     = press_q;
  assign saturated_o       = sat_out_q;

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted item did not enter the pipeline");

  a_last_stage_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LAST-1] && !in_stall_o) |=> out_valid_o)
    else $error("item lost before the output register");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(vld_q))
    else $error("pipeline moved while the output was held");

endmodule

FILE: src/bsc_mul.sv
module bsc_mul (
  input  logic                clk_i,
  input  logic                en_i,
  input  bsc_pkg::mul_a_t     a_i,
  input  bsc_pkg::mul_b_t     b_i,
  output bsc_pkg::mul_p_t     p_o
);

  bsc_pkg::mul_pp_t pp_d [bsc_pkg::MUL_NCH];
  bsc_pkg::mul_pp_t pp_q [bsc_pkg::MUL_NCH];
  bsc_pkg::mul_p_t  p_d;
  bsc_pkg::mul_p_t  p_q;

  // Partial products: lower chunks unsigned, top chunk carries the sign
  always_comb begin
    for (int k = 0; k < bsc_pkg::MUL_NCH; k++) begin
      if (k == bsc_pkg::MUL_NCH - 1) begin
        pp_d[k] = $signed(a_i[bsc_pkg::MUL_A_W-1 -: bsc_pkg::MUL_CH]) * b_i;
      end else begin
        pp_d[k] = $signed({1'b0, a_i[k*bsc_pkg::MUL_CH +: bsc_pkg::MUL_CH]}) * b_i;
      end
    end
  end

  always_comb begin
    p_d = '0;
    for (int k = 0; k < bsc_pkg::MUL_NCH; k++) begin
      p_d = p_d + (bsc_pkg::mul_p_t'(pp_q[k]) <<< (k * bsc_pkg::MUL_CH));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q <= pp_d;
      p_q  <= p_d;
    end
  end

  assign p_o = p_q;

endmodule
